// ===== design/obbt_pkg.sv =====
// Shared widths and constants for the oriented-box overlap pipeline.
package obbt_pkg;

  localparam int COORD_W = 24;  // signed Q15.8 center
  localparam int SIZE_W  = 23;  // unsigned Q15.8 full size
  localparam int TRIG_W  = 16;  // signed Q1.14 cos/sin
  localparam int DIFF_W  = 25;  // center difference, Q.8
  localparam int TT_W    = 32;  // trig * trig product, Q.28
  localparam int AX_W    = 33;  // axis dot axis, signed Q.28
  localparam int AXM_W   = 32;  // |axis dot axis|, at most 2^31
  localparam int DP_W    = 41;  // diff * trig product, Q.22
  localparam int DS_W    = 42;  // diff dot axis, signed Q.22
  localparam int DM_W    = 41;  // |diff dot axis|, at most 2^40
  localparam int EP_W    = 55;  // size * |axis dot axis|, Q.36
  localparam int CMP_W   = 57;  // doubled compare domain, Q.36

  // Shifts that line both sides of the compare up in Q.36 (the 0.5 factor
  // on the extents is folded in by doubling everything).
  localparam int LHS_SHIFT = 15;
  localparam int OWN_SHIFT = 28;

  // Pipeline depth: four stages in the top, two in each axis unit.
  localparam int PIPE_DEPTH = 6;

endpackage

// ===== design/obbt_axis_cmp.sv =====
// One separating-axis check: builds both sides in Q.36, then compares.
module obbt_axis_cmp (
  input  logic                         clk,
  input  logic                         en,
  input  logic [obbt_pkg::DM_W-1:0]    proj_mag,
  input  logic [obbt_pkg::SIZE_W-1:0]  own_size,
  input  logic [obbt_pkg::EP_W-1:0]    ext_p,
  input  logic [obbt_pkg::EP_W-1:0]    ext_q,
  output logic                         sep
);
  import obbt_pkg::*;

  logic [CMP_W-1:0] lhs;
  logic [CMP_W-1:0] rhs;

  // stage 5: 2c and 2(a+b)
  always_ff @(posedge clk) begin
    if (en) begin
      lhs <= CMP_W'({proj_mag, {LHS_SHIFT{1'b0}}});
      rhs <= CMP_W'({own_size, {OWN_SHIFT{1'b0}}}) + CMP_W'(ext_p) + CMP_W'(ext_q);
    end
  end

  // stage 6: strict compare, touching is not a separation
  always_ff @(posedge clk) begin
    if (en) begin
      sep <= (lhs > rhs);
    end
  end

endmodule

// ===== design/obb_overlap_test_2d.sv =====
// Top level: pipelined separating-axis overlap test for two oriented boxes.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | box_a_* and box_b_* center, size, cos, sin
//  out     | out_valid / out_ready| overlap
//
// Six register stages; one pair enters every cycle unless the output stalls.
// The depth is set by the multiply chain: trig products, diff products,
// size products, then the three-way add and the compare.
// rst clears only the stage valid bits; data registers are not reset.
// The last stage doubles as the output register. When it holds an item
// that is not taken, the whole pipeline freezes in place.
module obb_overlap_test_2d (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [obbt_pkg::COORD_W-1:0] box_a_center_x,
  input  logic signed [obbt_pkg::COORD_W-1:0] box_a_center_y,
  input  logic        [obbt_pkg::SIZE_W-1:0]  box_a_width,
  input  logic        [obbt_pkg::SIZE_W-1:0]  box_a_height,
  input  logic signed [obbt_pkg::TRIG_W-1:0]  box_a_cos,
  input  logic signed [obbt_pkg::TRIG_W-1:0]  box_a_sin,
  input  logic signed [obbt_pkg::COORD_W-1:0] box_b_center_x,
  input  logic signed [obbt_pkg::COORD_W-1:0] box_b_center_y,
  input  logic        [obbt_pkg::SIZE_W-1:0]  box_b_width,
  input  logic        [obbt_pkg::SIZE_W-1:0]  box_b_height,
  input  logic signed [obbt_pkg::TRIG_W-1:0]  box_b_cos,
  input  logic signed [obbt_pkg::TRIG_W-1:0]  box_b_sin,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           overlap
);
  import obbt_pkg::*;

  // Valid bit per stage; index PIPE_DEPTH-1 is the output stage.
  logic [PIPE_DEPTH-1:0] vld;
  logic                  en;

  // Global advance: move whenever the output slot is empty or being taken.
  assign en        = !vld[PIPE_DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // ---------------- stage 1: center difference, trig cross products
  logic signed [DIFF_W-1:0] s1_dx, s1_dy;
  logic signed [TT_W-1:0]   s1_cc, s1_ss, s1_sc, s1_cs;
  logic signed [TRIG_W-1:0] s1_ca, s1_sa, s1_cb, s1_sb;
  logic [SIZE_W-1:0]        s1_aw, s1_ah, s1_bw, s1_bh;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx <= DIFF_W'(box_b_center_x) - DIFF_W'(box_a_center_x);
      s1_dy <= DIFF_W'(box_b_center_y) - DIFF_W'(box_a_center_y);
      s1_cc <= TT_W'(box_a_cos) * TT_W'(box_b_cos);
      s1_ss <= TT_W'(box_a_sin) * TT_W'(box_b_sin);
      s1_sc <= TT_W'(box_a_sin) * TT_W'(box_b_cos);
      s1_cs <= TT_W'(box_a_cos) * TT_W'(box_b_sin);
      s1_ca <= box_a_cos;
      s1_sa <= box_a_sin;
      s1_cb <= box_b_cos;
      s1_sb <= box_b_sin;
      s1_aw <= box_a_width;
      s1_ah <= box_a_height;
      s1_bw <= box_b_width;
      s1_bh <= box_b_height;
    end
  end

  // ---------------- stage 2: axis dots, difference times trig
  // With up = right turned 90 deg, every axis-to-axis dot is +-P or +-Q:
  //   P = ca*cb + sa*sb,  Q = sa*cb - ca*sb
  logic signed [AX_W-1:0] s2_p, s2_q;
  logic signed [DP_W-1:0] s2_xca, s2_ysa, s2_xsa, s2_yca;
  logic signed [DP_W-1:0] s2_xcb, s2_ysb, s2_xsb, s2_ycb;
  logic [SIZE_W-1:0]      s2_aw, s2_ah, s2_bw, s2_bh;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p   <= AX_W'(s1_cc) + AX_W'(s1_ss);
      s2_q   <= AX_W'(s1_sc) - AX_W'(s1_cs);
      s2_xca <= DP_W'(s1_dx) * DP_W'(s1_ca);
      s2_ysa <= DP_W'(s1_dy) * DP_W'(s1_sa);
      s2_xsa <= DP_W'(s1_dx) * DP_W'(s1_sa);
      s2_yca <= DP_W'(s1_dy) * DP_W'(s1_ca);
      s2_xcb <= DP_W'(s1_dx) * DP_W'(s1_cb);
      s2_ysb <= DP_W'(s1_dy) * DP_W'(s1_sb);
      s2_xsb <= DP_W'(s1_dx) * DP_W'(s1_sb);
      s2_ycb <= DP_W'(s1_dy) * DP_W'(s1_cb);
      s2_aw  <= s1_aw;
      s2_ah  <= s1_ah;
      s2_bw  <= s1_bw;
      s2_bh  <= s1_bh;
    end
  end

  // ---------------- stage 3: |P|, |Q| and the four d.axis sums
  logic signed [AX_W-1:0] neg_p, neg_q;
  logic [AXM_W-1:0]       s3_mp, s3_mq;
  logic signed [DS_W-1:0] s3_d1, s3_d2, s3_d3, s3_d4;
  logic [SIZE_W-1:0]      s3_aw, s3_ah, s3_bw, s3_bh;

  assign neg_p = -s2_p;
  assign neg_q = -s2_q;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mp <= s2_p[AX_W-1] ? neg_p[AXM_W-1:0] : s2_p[AXM_W-1:0];
      s3_mq <= s2_q[AX_W-1] ? neg_q[AXM_W-1:0] : s2_q[AXM_W-1:0];
      s3_d1 <= DS_W'(s2_xca) + DS_W'(s2_ysa);  // right_a
      s3_d2 <= DS_W'(s2_yca) - DS_W'(s2_xsa);  // up_a
      s3_d3 <= DS_W'(s2_xcb) + DS_W'(s2_ysb);  // right_b
      s3_d4 <= DS_W'(s2_ycb) - DS_W'(s2_xsb);  // up_b
      s3_aw <= s2_aw;
      s3_ah <= s2_ah;
      s3_bw <= s2_bw;
      s3_bh <= s2_bh;
    end
  end

  // ---------------- stage 4: size * |axis dot| products, |d.axis|
  logic signed [DS_W-1:0] neg_d1, neg_d2, neg_d3, neg_d4;
  logic [DM_W-1:0]        s4_m1, s4_m2, s4_m3, s4_m4;
  logic [EP_W-1:0]        s4_bw_mp, s4_bh_mq, s4_bh_mp, s4_bw_mq;
  logic [EP_W-1:0]        s4_aw_mp, s4_ah_mq, s4_ah_mp, s4_aw_mq;
  logic [SIZE_W-1:0]      s4_aw, s4_ah, s4_bw, s4_bh;

  assign neg_d1 = -s3_d1;
  assign neg_d2 = -s3_d2;
  assign neg_d3 = -s3_d3;
  assign neg_d4 = -s3_d4;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_m1    <= s3_d1[DS_W-1] ? neg_d1[DM_W-1:0] : s3_d1[DM_W-1:0];
      s4_m2    <= s3_d2[DS_W-1] ? neg_d2[DM_W-1:0] : s3_d2[DM_W-1:0];
      s4_m3    <= s3_d3[DS_W-1] ? neg_d3[DM_W-1:0] : s3_d3[DM_W-1:0];
      s4_m4    <= s3_d4[DS_W-1] ? neg_d4[DM_W-1:0] : s3_d4[DM_W-1:0];
      s4_bw_mp <= EP_W'(s3_bw) * EP_W'(s3_mp);
      s4_bh_mq <= EP_W'(s3_bh) * EP_W'(s3_mq);
      s4_bh_mp <= EP_W'(s3_bh) * EP_W'(s3_mp);
      s4_bw_mq <= EP_W'(s3_bw) * EP_W'(s3_mq);
      s4_aw_mp <= EP_W'(s3_aw) * EP_W'(s3_mp);
      s4_ah_mq <= EP_W'(s3_ah) * EP_W'(s3_mq);
      s4_ah_mp <= EP_W'(s3_ah) * EP_W'(s3_mp);
      s4_aw_mq <= EP_W'(s3_aw) * EP_W'(s3_mq);
      s4_aw    <= s3_aw;
      s4_ah    <= s3_ah;
      s4_bw    <= s3_bw;
      s4_bh    <= s3_bh;
    end
  end

  // ---------------- stages 5-6: one compare unit per axis
  // right_a: other extent = bh*|ub.ra| + bw*|rb.ra| = bh*|Q| + bw*|P|
  // up_a:    bh*|P| + bw*|Q|
  // right_b: ah*|Q| + aw*|P|
  // up_b:    ah*|P| + aw*|Q|
  logic [3:0] sep;

  obbt_axis_cmp u_ax_ra (
    .clk(clk), .en(en), .proj_mag(s4_m1), .own_size(s4_aw),
    .ext_p(s4_bw_mp), .ext_q(s4_bh_mq), .sep(sep[0])
  );

  obbt_axis_cmp u_ax_ua (
    .clk(clk), .en(en), .proj_mag(s4_m2), .own_size(s4_ah),
    .ext_p(s4_bh_mp), .ext_q(s4_bw_mq), .sep(sep[1])
  );

  obbt_axis_cmp u_ax_rb (
    .clk(clk), .en(en), .proj_mag(s4_m3), .own_size(s4_bw),
    .ext_p(s4_aw_mp), .ext_q(s4_ah_mq), .sep(sep[2])
  );

  obbt_axis_cmp u_ax_ub (
    .clk(clk), .en(en), .proj_mag(s4_m4), .own_size(s4_bh),
    .ext_p(s4_ah_mp), .ext_q(s4_aw_mq), .sep(sep[3])
  );

  // No separating axis found: the boxes overlap (touching included).
  assign overlap = ~|sep;

  // ---------------- checks
  a_rst_clears: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("valid bits not cleared by reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during a stall");

  a_axis_dot_bound: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (s3_mp <= AXM_W'(64'h8000_0000)) && (s3_mq <= AXM_W'(64'h8000_0000)))
    else $error("axis dot magnitude out of range");

  a_proj_bound: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (s4_m1[DM_W-1] == 1'b0 || s4_m1[DM_W-2:0] == '0) &&
               (s4_m4[DM_W-1] == 1'b0 || s4_m4[DM_W-2:0] == '0))
    else $error("projected distance out of range");

endmodule

// ===== bench/tb_obb_overlap_test_2d.sv =====
// obb_overlap_test_2d bench: directed, then random pairs checked by a predictor.
module tb_obb_overlap_test_2d;
  timeunit 1ns;
  timeprecision 1ps;

  import obbt_pkg::*;

  localparam int RANDOM_PAIRS = 1330;
  localparam int STALL_LIMIT  = 1000;  // cycles with no handshake on either side
  localparam int MAX_REPORTS  = 10;
  localparam int Q14_ONE      = 16384;
  localparam int COORD_MAX    = 2**(COORD_W-1) - 1;
  localparam int COORD_MIN    = -(2**(COORD_W-1));
  localparam int SIZE_MAX     = 2**SIZE_W - 1;

  // How a directed row is checked: by the predictor, or against a value
  // that is obvious by inspection.
  typedef enum logic [1:0] {CHK_PREDICT, CHK_HIT, CHK_MISS} check_t;

  // One input item; field order matches the port list.
  typedef struct packed {
    logic signed [COORD_W-1:0] box_a_center_x;
    logic signed [COORD_W-1:0] box_a_center_y;
    logic        [SIZE_W-1:0]  box_a_width;
    logic        [SIZE_W-1:0]  box_a_height;
    logic signed [TRIG_W-1:0]  box_a_cos;
    logic signed [TRIG_W-1:0]  box_a_sin;
    logic signed [COORD_W-1:0] box_b_center_x;
    logic signed [COORD_W-1:0] box_b_center_y;
    logic        [SIZE_W-1:0]  box_b_width;
    logic        [SIZE_W-1:0]  box_b_height;
    logic signed [TRIG_W-1:0]  box_b_cos;
    logic signed [TRIG_W-1:0]  box_b_sin;
  } box_pair_t;

  typedef struct packed {
    box_pair_t pair;
    check_t    chk;
  } stim_row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, overlap;

  // Payload is held in one register and fanned out to the ports, so a new
  // item is a single assignment.
  box_pair_t drv_pair;
  check_t    drv_check;

  logic signed [COORD_W-1:0] box_a_center_x, box_a_center_y, box_b_center_x, box_b_center_y;
  logic        [SIZE_W-1:0]  box_a_width, box_a_height, box_b_width, box_b_height;
  logic signed [TRIG_W-1:0]  box_a_cos, box_a_sin, box_b_cos, box_b_sin;

  assign {box_a_center_x, box_a_center_y, box_a_width, box_a_height, box_a_cos, box_a_sin,
          box_b_center_x, box_b_center_y, box_b_width, box_b_height, box_b_cos, box_b_sin}
         = drv_pair;

  logic overlap_expect_q[$];  // predicted overlap flags, oldest first
  logic overlap_want;
  int   fail_count = 0;
  int   results_seen = 0;
  int   idle_cycles = 0;

  obb_overlap_test_2d dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .box_a_center_x(box_a_center_x),
    .box_a_center_y(box_a_center_y),
    .box_a_width   (box_a_width),
    .box_a_height  (box_a_height),
    .box_a_cos     (box_a_cos),
    .box_a_sin     (box_a_sin),
    .box_b_center_x(box_b_center_x),
    .box_b_center_y(box_b_center_y),
    .box_b_width   (box_b_width),
    .box_b_height  (box_b_height),
    .box_b_cos     (box_b_cos),
    .box_b_sin     (box_b_sin),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .overlap       (overlap)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Separating-axis test on the edge normals of both boxes, all in 64-bit integers.
  // Both sides of each compare are doubled and aligned to Q.36:
  //   center gap   |d . axis| (Q.22) << 15
  //   own half     size (Q.8) << 28
  //   other box    h * |up . axis| + w * |right . axis|  (Q.8 * Q.28)
  // Strictly greater separates; touching still counts as overlap.
  function automatic logic predict_overlap(box_pair_t p);
    longint cs[2], sn[2], wd[2], ht[2];
    longint dx, dy, axx, axy, proj_r, proj_u, lhs, rhs, own_size;
    int     own, oth;
    logic   apart;
    cs[0] = longint'($signed(p.box_a_cos));
    sn[0] = longint'($signed(p.box_a_sin));
    wd[0] = longint'(p.box_a_width);
    ht[0] = longint'(p.box_a_height);
    cs[1] = longint'($signed(p.box_b_cos));
    sn[1] = longint'($signed(p.box_b_sin));
    wd[1] = longint'(p.box_b_width);
    ht[1] = longint'(p.box_b_height);
    dx = longint'($signed(p.box_b_center_x)) - longint'($signed(p.box_a_center_x));
    dy = longint'($signed(p.box_b_center_y)) - longint'($signed(p.box_a_center_y));
    apart = 1'b0;
    // axes in order: right_a, up_a, right_b, up_b; up = right turned by 90 degrees
    for (int k = 0; k < 4; k++) begin
      own = k / 2;
      oth = 1 - own;
      if (k % 2 == 0) begin
        axx = cs[own];
        axy = sn[own];
        own_size = wd[own];
      end else begin
        axx = -sn[own];
        axy = cs[own];
        own_size = ht[own];
      end
      proj_r = cs[oth] * axx + sn[oth] * axy;
      proj_u = -sn[oth] * axx + cs[oth] * axy;
      lhs = abs64(dx * axx + dy * axy) << 15;
      rhs = (own_size << 28) + ht[oth] * abs64(proj_u) + wd[oth] * abs64(proj_r);
      if (lhs > rhs) apart = 1'b1;
    end
    return !apart;
  endfunction

  function automatic stim_row_t mk_row(int ax, int ay, int aw, int ah, int a_cs, int a_sn,
                                       int bx, int by, int bw, int bh, int b_cs, int b_sn,
                                       check_t chk);
    stim_row_t r;
    r.pair.box_a_center_x = ax[COORD_W-1:0];
    r.pair.box_a_center_y = ay[COORD_W-1:0];
    r.pair.box_a_width    = aw[SIZE_W-1:0];
    r.pair.box_a_height   = ah[SIZE_W-1:0];
    r.pair.box_a_cos      = a_cs[TRIG_W-1:0];
    r.pair.box_a_sin      = a_sn[TRIG_W-1:0];
    r.pair.box_b_center_x = bx[COORD_W-1:0];
    r.pair.box_b_center_y = by[COORD_W-1:0];
    r.pair.box_b_width    = bw[SIZE_W-1:0];
    r.pair.box_b_height   = bh[SIZE_W-1:0];
    r.pair.box_b_cos      = b_cs[TRIG_W-1:0];
    r.pair.box_b_sin      = b_sn[TRIG_W-1:0];
    r.chk = chk;
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(longint v);
    if (v > COORD_MAX) return COORD_W'(COORD_MAX);
    if (v < COORD_MIN) return COORD_W'(COORD_MIN);
    return v[COORD_W-1:0];
  endfunction

  // Unit direction in Q1.14; sometimes exactly axis-aligned.
  function automatic logic [2*TRIG_W-1:0] rand_dir();
    real ang;
    int  c, s;
    if ($urandom_range(0, 7) == 0) begin
      c = $urandom_range(0, 1) ? Q14_ONE : -Q14_ONE;
      s = 0;
    end else begin
      ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
      c = $rtoi($cos(ang) * Q14_ONE);
      s = $rtoi($sin(ang) * Q14_ONE);
    end
    return {c[TRIG_W-1:0], s[TRIG_W-1:0]};
  endfunction

  // Mostly realistic pairs: unit rotations, box b placed within reach of box a
  // so both outcomes are common. One in five is raw bit noise, which covers
  // every field bit and the out-of-range trig codes.
  function automatic box_pair_t rand_pair();
    box_pair_t    p;
    logic [255:0] noise;
    int           mode, sa, sb, span;
    longint       off;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p = noise[$bits(box_pair_t)-1:0];
      return p;
    end
    // most sizes small, the largest only now and then
    sa = $urandom_range(1, (mode == 9) ? SIZE_W : 18);
    sb = $urandom_range(1, (mode == 9) ? SIZE_W : 18);
    p.box_a_width  = SIZE_W'($urandom & ((1 << sa) - 1));
    p.box_a_height = SIZE_W'($urandom & ((1 << sa) - 1));
    p.box_b_width  = SIZE_W'($urandom & ((1 << sb) - 1));
    p.box_b_height = SIZE_W'($urandom & ((1 << sb) - 1));
    {p.box_a_cos, p.box_a_sin} = rand_dir();
    {p.box_b_cos, p.box_b_sin} = rand_dir();
    p.box_a_center_x = COORD_W'($urandom);
    p.box_a_center_y = COORD_W'($urandom);
    span = int'(p.box_a_width) + int'(p.box_a_height)
         + int'(p.box_b_width) + int'(p.box_b_height);
    span = (mode < 6) ? span / 2 + 1 : span + 1;
    off = longint'($urandom_range(0, 2 * span)) - longint'(span);
    p.box_b_center_x = sat_coord(longint'($signed(p.box_a_center_x)) + off);
    off = longint'($urandom_range(0, 2 * span)) - longint'(span);
    p.box_b_center_y = sat_coord(longint'($signed(p.box_a_center_y)) + off);
    return p;
  endfunction

  // Present one item at a falling edge and hold it until accepted.
  // Valid is only lowered when a gap is actually taken.
  task automatic send_pair(box_pair_t p, check_t chk, logic burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    drv_pair  <= p;
    drv_check <= chk;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (overlap_expect_q.size() != 0);
  endtask

  // Sender: reset, directed rows, then random pairs.
  initial begin
    stim_row_t dir_rows[$];
    logic      burst;
    rst       = 1'b1;
    in_valid  = 1'b0;
    drv_pair  = '0;
    drv_check = CHK_PREDICT;
    burst     = 1'b0;

    // all zero: two points on the origin, nothing can exceed zero
    dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, CHK_HIT));
    // identical aligned unit squares
    dir_rows.push_back(mk_row(0, 0, 256, 256, Q14_ONE, 0,
                              0, 0, 256, 256, Q14_ONE, 0, CHK_HIT));
    // edges touch exactly along x: touching is overlap
    dir_rows.push_back(mk_row(0, 0, 512, 256, Q14_ONE, 0,
                              512, 0, 512, 256, Q14_ONE, 0, CHK_HIT));
    // one LSB further and the gap opens
    dir_rows.push_back(mk_row(0, 0, 512, 256, Q14_ONE, 0,
                              513, 0, 512, 256, Q14_ONE, 0, CHK_MISS));
    // two points one LSB apart
    dir_rows.push_back(mk_row(0, 0, 0, 0, Q14_ONE, 0, 0, 1, 0, 0, Q14_ONE, 0, CHK_MISS));
    // zero trig collapses every axis, even at opposite corners of the range
    dir_rows.push_back(mk_row(COORD_MIN, COORD_MIN, 0, 0, 0, 0,
                              COORD_MAX, COORD_MAX, 0, 0, 0, 0, CHK_HIT));
    // opposite range corners, points
    dir_rows.push_back(mk_row(COORD_MIN, COORD_MIN, 0, 0, Q14_ONE, 0,
                              COORD_MAX, COORD_MAX, 0, 0, Q14_ONE, 0, CHK_MISS));
    // same corners, largest sizes
    dir_rows.push_back(mk_row(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, Q14_ONE, 0,
                              COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, Q14_ONE, 0,
                              CHK_PREDICT));
    // all-ones patterns: centers -1, max sizes, trig -1
    dir_rows.push_back(mk_row(-1, -1, SIZE_MAX, SIZE_MAX, -1, -1,
                              -1, -1, SIZE_MAX, SIZE_MAX, -1, -1, CHK_PREDICT));
    // largest sizes on a shared center, rotated: zero gap always overlaps
    dir_rows.push_back(mk_row(0, 0, SIZE_MAX, SIZE_MAX, 14189, 8192,
                              0, 0, SIZE_MAX, SIZE_MAX, -8192, 14189, CHK_HIT));
    // out-of-range trig: most negative and most positive codes
    dir_rows.push_back(mk_row(-1000, 2000, 5000, 300, -32768, -32768,
                              3000, -4000, 700, 9000, -32768, 32767, CHK_PREDICT));
    dir_rows.push_back(mk_row(0, 0, 4096, 4096, 32767, 32767,
                              6000, 0, 4096, 4096, 32767, -32768, CHK_PREDICT));
    // 45 degree diamond against an aligned square, near and past the corner
    dir_rows.push_back(mk_row(0, 0, 1024, 1024, 11585, 11585,
                              1100, 1100, 1024, 1024, Q14_ONE, 0, CHK_PREDICT));
    dir_rows.push_back(mk_row(0, 0, 1024, 1024, 11585, 11585,
                              1400, 1400, 1024, 1024, Q14_ONE, 0, CHK_PREDICT));
    // box b turned 90 degrees, its width along y
    dir_rows.push_back(mk_row(0, 0, 512, 512, Q14_ONE, 0,
                              0, 700, 1024, 256, 0, Q14_ONE, CHK_PREDICT));
    // mirrored axes
    dir_rows.push_back(mk_row(0, 0, 512, 512, -Q14_ONE, 0,
                              600, 0, 512, 512, 0, -Q14_ONE, CHK_PREDICT));
    // zero-width segment against a point, aligned and rotated
    dir_rows.push_back(mk_row(0, 0, 0, SIZE_MAX, Q14_ONE, 0,
                              0, -1000, 0, 0, Q14_ONE, 0, CHK_PREDICT));
    dir_rows.push_back(mk_row(0, 0, 0, 2048, 11585, -11585,
                              500, 500, 0, 0, Q14_ONE, 0, CHK_PREDICT));
    // non-unit trig: both components at full scale
    dir_rows.push_back(mk_row(0, 0, 2048, 1024, Q14_ONE, Q14_ONE,
                              3000, -2500, 1024, 2048, -Q14_ONE, Q14_ONE, CHK_PREDICT));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_pair(dir_rows[i].pair, dir_rows[i].chk, 1'b0);
    hold_until_drained();

    // random pairs; every 50 items pick gapped or back-to-back sending
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_PAIRS / 2) hold_until_drained();
      send_pair(rand_pair(), CHK_PREDICT, burst);
    end
    in_valid <= 1'b0;

    // drain, then linger so a stray extra result would be caught
    while (overlap_expect_q.size() != 0) @(posedge clk);
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (fail_count == 0 && overlap_expect_q.size() == 0) begin
      $display("obb_overlap_test_2d test passed");
    end else begin
      $display("obb_overlap_test_2d test failed");
    end
    $finish;
  end

  // Receiver: random stall before each result, with stretches of none.
  initial begin
    int   gap;
    int   taken;
    logic burst;
    out_ready = 1'b0;
    taken     = 0;
    burst     = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // Scoreboard and watchdog. Accepted inputs are predicted first, so even a
  // result leaving in the same cycle as its input would find its entry.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        case (drv_check)
          CHK_HIT:  overlap_expect_q.push_back(1'b1);
          CHK_MISS: overlap_expect_q.push_back(1'b0);
          default:  overlap_expect_q.push_back(predict_overlap(drv_pair));
        endcase
      end
      if (out_valid && out_ready) begin
        if (overlap_expect_q.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("result %0d: overlap %b with nothing outstanding", results_seen, overlap);
          fail_count++;
        end else begin
          overlap_want = overlap_expect_q.pop_front();
          if (overlap !== overlap_want) begin
            if (fail_count < MAX_REPORTS)
              $display("result %0d: overlap %b, expected %b",
                       results_seen, overlap, overlap_want);
            fail_count++;
          end
        end
        results_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("obb_overlap_test_2d test failed");
        $finish;
      end
    end
  end

endmodule
